>>> rtl/lpt_split_pkg.sv
`default_nettype none

package lpt_split_pkg;

  localparam int unsigned MaxJobsDefault  = 16;
  localparam int unsigned CostBitsDefault = 16;

  localparam int unsigned JobIndexW = 6;
  localparam int unsigned SumW      = 22;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic SideInline = 1'b0;
  localparam logic SideWorker = 1'b1;

  localparam logic CfgIdxGlobalSeq   = 1'b0;
  localparam logic CfgIdxWorkerReady = 1'b1;

  // Outcome of placing one job on a side
  typedef struct packed {
    logic            side;
    logic [SumW-1:0] inline_sum;
    logic [SumW-1:0] worker_sum;
  } assign_t;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StInsert = 3'b010,
    StEmit   = 3'b100
  } state_e;

endpackage

`default_nettype wire

>>> rtl/lpt_split_assign.sv
`default_nettype none

module lpt_split_assign #(
  parameter int unsigned COST_BITS = lpt_split_pkg::CostBitsDefault
) (
  input  wire logic                          split_i,
  input  wire logic [COST_BITS-1:0]          cost_i,
  input  wire logic [lpt_split_pkg::SumW-1:0] inline_sum_i,
  input  wire logic [lpt_split_pkg::SumW-1:0] worker_sum_i,
  output lpt_split_pkg::assign_t             result_o
);
  import lpt_split_pkg::*;

  localparam int unsigned ExtW = ((COST_BITS > SumW) ? COST_BITS : SumW) + 1;

  logic            to_worker;
  logic [SumW-1:0] base_sum;
  logic [ExtW-1:0] wide_sum;
  logic [SumW-1:0] sat_sum;

  // Equal loads go inline; sequential mode never picks the worker
  assign to_worker = split_i && (inline_sum_i > worker_sum_i);
  assign base_sum  = to_worker ? worker_sum_i : inline_sum_i;
  assign wide_sum  = ExtW'(base_sum) + ExtW'(cost_i);
  assign sat_sum   = (wide_sum > ExtW'(SumMax)) ? SumMax : wide_sum[SumW-1:0];

  always_comb begin
    result_o.side       = to_worker ? SideWorker : SideInline;
    result_o.inline_sum = to_worker ? inline_sum_i : sat_sum;
    result_o.worker_sum = to_worker ? sat_sum : worker_sum_i;
  end

endmodule

`default_nettype wire

>>> rtl/two_way_lpt_load_split_unit.sv
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid_i/in_stall_o   job_cost_i, batch_sequential_i, last_job_i
// out       out_valid_o/out_stall_i job_index_o, side_o, inline_total_o,
//                                   worker_total_o, split_used_o, last_result_o
// cfg       cfg_we_i                cfg_index_i, cfg_data_i
//
// Each job but the first of a batch walks in from the tail of the sorted list,
// moving past one lighter entry a cycle and then being placed, set by the single
// write port of the sorted-list memory. A last job adds a first read of the list
// and then one result per cycle while out_stall_i is low; output stalls hold the
// emission loop. Reset clears the job count and running totals; the list
// memories need no clearing.
module two_way_lpt_load_split_unit #(
  parameter int unsigned MAX_JOBS  = lpt_split_pkg::MaxJobsDefault,
  parameter int unsigned COST_BITS = lpt_split_pkg::CostBitsDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_index_i,
  input  wire logic                                 cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [COST_BITS-1:0]                 job_cost_i,
  input  wire logic                                 batch_sequential_i,
  input  wire logic                                 last_job_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [lpt_split_pkg::JobIndexW-1:0]       job_index_o,
  output logic                                      side_o,
  output logic [lpt_split_pkg::SumW-1:0]            inline_total_o,
  output logic [lpt_split_pkg::SumW-1:0]            worker_total_o,
  output logic                                      split_used_o,
  output logic                                      last_result_o
);
  import lpt_split_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_JOBS);
  localparam int unsigned CntW   = $clog2(MAX_JOBS + 1);
  localparam int unsigned EntryW = IdxW + COST_BITS;

  // Sorted list, heaviest first: {arrival index, cost}
  logic [EntryW-1:0]    sort_mem [MAX_JOBS];
  // Costs in arrival order, for sequential emission
  logic [COST_BITS-1:0] arr_mem  [MAX_JOBS];

  state_e state_q, state_d;

  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      ins_k_q, ins_k_d;
  logic [IdxW-1:0]      emit_k_q, emit_k_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [COST_BITS-1:0] cost_q;
  logic                 last_q;
  logic                 bseq_q;
  logic                 gseq_q;
  logic                 wready_q;
  logic [SumW-1:0]      inl_sum_q, inl_sum_d;
  logic [SumW-1:0]      wrk_sum_q, wrk_sum_d;

  logic                 out_valid_q, out_valid_d;
  logic [JobIndexW-1:0] out_index_q;
  logic                 out_side_q;
  logic [SumW-1:0]      out_inl_q;
  logic [SumW-1:0]      out_wrk_q;
  logic                 out_split_q;
  logic                 out_last_q;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [EntryW-1:0]    sort_rd_q;
  logic [COST_BITS-1:0] arr_rd_q;

  logic                 sort_we;
  logic [IdxW-1:0]      sort_waddr;
  logic [EntryW-1:0]    sort_wdata;
  logic                 arr_we;
  logic [IdxW-1:0]      arr_waddr;

  logic                 accept;
  logic                 split;
  logic                 emit_last;
  logic                 out_load;
  logic [COST_BITS-1:0] rd_cost;
  logic [IdxW-1:0]      rd_index;
  logic [COST_BITS-1:0] emit_cost;
  logic [IdxW-1:0]      emit_index;
  assign_t              asg;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_cost  = sort_rd_q[COST_BITS-1:0];
  assign rd_index = sort_rd_q[EntryW-1:COST_BITS];

  assign split      = !gseq_q && !bseq_q && wready_q && (count_q >= CntW'(2));
  assign emit_last  = ((CntW'(emit_k_q) + CntW'(1)) == count_q);
  assign emit_cost  = split ? rd_cost : arr_rd_q;
  assign emit_index = split ? rd_index : emit_k_q;
  assign out_load   = (state_q == StEmit) && rd_ok_q && (!out_valid_q || !out_stall_i);

  lpt_split_assign #(
    .COST_BITS (COST_BITS)
  ) u_assign (
    .split_i      (split),
    .cost_i       (emit_cost),
    .inline_sum_i (inl_sum_q),
    .worker_sum_i (wrk_sum_q),
    .result_o     (asg)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ins_k_d    = ins_k_q;
    emit_k_d   = emit_k_q;
    rd_ok_d    = rd_ok_q;
    inl_sum_d  = inl_sum_q;
    wrk_sum_d  = wrk_sum_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    sort_we    = 1'b0;
    sort_waddr = '0;
    sort_wdata = {count_q[IdxW-1:0], cost_q};
    arr_we     = 1'b0;
    arr_waddr  = count_q[IdxW-1:0];
    case (state_q)
      StIdle: begin
        emit_k_d = '0;
        rd_ok_d  = 1'b0;
        if (accept) begin
          if (count_q < CntW'(MAX_JOBS)) begin
            arr_we = 1'b1;
            if (count_q == '0) begin
              sort_we    = 1'b1;
              sort_wdata = {IdxW'(0), job_cost_i};
              count_d    = count_q + CntW'(1);
              if (last_job_i) begin
                state_d = StEmit;
              end
            end else begin
              // Start the walk from the tail of the list
              rd_en   = 1'b1;
              rd_addr = count_q[IdxW-1:0] - IdxW'(1);
              ins_k_d = count_q[IdxW-1:0];
              state_d = StInsert;
            end
          end else if (last_job_i) begin
            state_d = StEmit;
          end
        end
      end
      StInsert: begin
        // sort_rd_q holds entry ins_k_q - 1 unless the walk reached the head
        if ((ins_k_q != '0) && (rd_cost < cost_q)) begin
          sort_we    = 1'b1;
          sort_waddr = ins_k_q;
          sort_wdata = sort_rd_q;
          ins_k_d    = ins_k_q - IdxW'(1);
          if (ins_k_q != IdxW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ins_k_q - IdxW'(2);
          end
        end else begin
          sort_we    = 1'b1;
          sort_waddr = ins_k_q;
          count_d    = count_q + CntW'(1);
          state_d    = last_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (!rd_ok_q) begin
          rd_en   = 1'b1;
          rd_addr = emit_k_q;
          rd_ok_d = 1'b1;
        end else if (out_load) begin
          if (emit_last) begin
            count_d   = '0;
            inl_sum_d = '0;
            wrk_sum_d = '0;
            rd_ok_d   = 1'b0;
            state_d   = StIdle;
          end else begin
            inl_sum_d = asg.inline_sum;
            wrk_sum_d = asg.worker_sum;
            rd_en     = 1'b1;
            rd_addr   = emit_k_q + IdxW'(1);
            emit_k_d  = emit_k_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (sort_we) begin
      sort_mem[sort_waddr] <= sort_wdata;
    end
    if (arr_we) begin
      arr_mem[arr_waddr] <= job_cost_i;
    end
    if (rd_en) begin
      sort_rd_q <= sort_mem[rd_addr];
      arr_rd_q  <= arr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cost_q <= job_cost_i;
      last_q <= last_job_i;
      bseq_q <= batch_sequential_i;
    end
    if (out_load) begin
      out_index_q <= JobIndexW'(emit_index);
      out_side_q  <= asg.side;
      out_inl_q   <= asg.inline_sum;
      out_wrk_q   <= asg.worker_sum;
      out_split_q <= split;
      out_last_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ins_k_q     <= '0;
      emit_k_q    <= '0;
      rd_ok_q     <= 1'b0;
      inl_sum_q   <= '0;
      wrk_sum_q   <= '0;
      out_valid_q <= 1'b0;
      gseq_q      <= 1'b0;
      wready_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ins_k_q     <= ins_k_d;
      emit_k_q    <= emit_k_d;
      rd_ok_q     <= rd_ok_d;
      inl_sum_q   <= inl_sum_d;
      wrk_sum_q   <= wrk_sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxGlobalSeq) begin
          gseq_q <= cfg_data_i;
        end else begin
          wready_q <= cfg_data_i;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign job_index_o    = out_index_q;
  assign side_o         = out_side_q;
  assign inline_total_o = out_inl_q;
  assign worker_total_o = out_wrk_q;
  assign split_used_o   = out_split_q;
  assign last_result_o  = out_last_q;

endmodule

`default_nettype wire
